// ===== hw/rtl/qsi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quintic spline interpolator package
// Shared widths, types, register indexes and saturating helpers.
// ----------------------------------------------------------------------------
package qsi_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int WORD_BITS   = 32;
    localparam int S_BITS      = 30;
    localparam int WIDE_W      = 63;
    localparam int MAG_W       = WIDE_W - 1;
    localparam int HALF_W      = MAG_W / 2;
    localparam int NUM_W       = MAG_W + FRAC_BITS;
    localparam int CFG_IDX_W   = 4;
    localparam int NUM_LANES   = 3;
    localparam int NUM_STEPS   = 5;
    localparam int FDIV_STEPS  = S_BITS;
    localparam int LDIV_STEPS  = MAG_W;
    localparam int SHIFT_W     = $clog2(FRAC_BITS + 1);
    localparam int DATA_W      = 3 * WORD_BITS;

    localparam int LANE_POS = 0;
    localparam int LANE_VEL = 1;
    localparam int LANE_ACC = 2;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [WIDE_W-1:0]    t_wide;
    typedef logic [MAG_W-1:0]            t_mag;
    typedef logic [S_BITS-1:0]           t_frac;
    typedef logic [WORD_BITS-1:0]        t_div;
    typedef logic [SHIFT_W-1:0]          t_shift;
    typedef logic [1:0]                  t_region;

    localparam t_region REGION_START  = 2'd0;
    localparam t_region REGION_INSIDE = 2'd1;
    localparam t_region REGION_END    = 2'd2;

    localparam t_shift SHIFT_VEL = t_shift'(FRAC_BITS - 1);
    localparam t_shift SHIFT_ACC = t_shift'(FRAC_BITS);

    localparam t_wide WIDE_LIM = t_wide'({1'b0, {MAG_W{1'b1}}});

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_TIME = 4'd0,
        CFG_END_TIME   = 4'd1,
        CFG_START_POS  = 4'd2,
        CFG_START_VEL  = 4'd3,
        CFG_START_ACC  = 4'd4,
        CFG_END_POS    = 4'd5,
        CFG_END_VEL    = 4'd6,
        CFG_END_ACC    = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        t_word start_time;
        t_word end_time;
        t_word start_pos;
        t_word start_vel;
        t_word start_acc;
        t_word end_pos;
        t_word end_vel;
        t_word end_acc;
    } t_knots;

    // travels beside the long divisions
    typedef struct packed {
        t_region region;
        t_wide   pos;
        t_wide   aux;
    } t_side;

    function automatic t_wide sat_add(input t_wide a, input t_wide b);
        logic signed [WIDE_W:0] s;
        logic signed [WIDE_W:0] lim;
        s   = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
        lim = {1'b0, WIDE_LIM};
        if (s > lim) begin
            return WIDE_LIM;
        end else if (s < -lim) begin
            return -WIDE_LIM;
        end
        return s[WIDE_W-1:0];
    endfunction

    function automatic t_word sat_word(input t_wide x);
        t_wide hi;
        t_wide lo;
        hi = t_wide'({1'b0, {(WORD_BITS-1){1'b1}}});
        lo = -hi - t_wide'(1);
        if (x > hi) begin
            return hi[WORD_BITS-1:0];
        end else if (x < lo) begin
            return lo[WORD_BITS-1:0];
        end
        return x[WORD_BITS-1:0];
    endfunction

endpackage

// ===== hw/rtl/qsi_coef.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Knot registers and coefficient sequencer
// Holds the knot registers and, after every write, derives the duration and
// the Horner coefficients of all three lanes over a short run of cycles.
// ----------------------------------------------------------------------------
module qsi_coef (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    input  logic [qsi_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  qsi_pkg::t_word                        i_cfg_data,
    output qsi_pkg::t_knots                       o_knots,
    output qsi_pkg::t_div                         o_div,
    output qsi_pkg::t_wide                        o_init [qsi_pkg::NUM_LANES],
    output qsi_pkg::t_wide                        o_add [qsi_pkg::NUM_STEPS][qsi_pkg::NUM_LANES],
    output logic                                  o_busy
);
    import qsi_pkg::*;

    localparam int PP_W    = HALF_W + WORD_BITS + 1;
    localparam int FULL_W  = PP_W + HALF_W;
    localparam int SHR_W   = FULL_W - FRAC_BITS;
    localparam int NUM_OPS = 6;
    localparam int OP_W    = $clog2(NUM_OPS);
    localparam logic [SHR_W-1:0] SHR_LIM = SHR_W'({1'b0, {MAG_W{1'b1}}});

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DUR   = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_TERM  = 8'b0000_1000,
        S_CA    = 8'b0001_0000,
        S_CB    = 8'b0010_0000,
        S_CC    = 8'b0100_0000,
        S_SCALE = 8'b1000_0000
    } t_state;

    t_state                    r_state;
    t_knots                    r_knots;
    logic signed [WORD_BITS:0] r_dur;
    logic [OP_W-1:0]           r_op;
    logic                      r_phase;
    logic [PP_W-1:0]           r_pl;
    logic [PP_W-1:0]           r_ph;
    logic                      r_mneg;
    t_wide r_nv0, r_nv1, r_tmp, r_na0, r_na1, r_t1, r_t2, r_t3, r_ca, r_cb, r_cc;
    t_wide r_init [NUM_LANES];
    t_wide r_add  [NUM_STEPS][NUM_LANES];

    t_wide                 w_sel;
    t_mag                  w_mx;
    logic [WORD_BITS:0]    w_md;
    logic [FULL_W-1:0]     w_full;
    logic [SHR_W-1:0]      w_shr;
    t_wide                 w_mmag;
    t_wide                 w_mres;
    t_wide                 w_p0;
    t_wide                 w_p1;

    // exact product by a small constant, saturated
    function automatic t_wide mul_k(input t_wide x, input logic [4:0] k);
        logic signed [WIDE_W+5:0] p;
        logic signed [WIDE_W+5:0] lim;
        p   = (WIDE_W+6)'(x) * $signed({1'b0, k});
        lim = (WIDE_W+6)'(WIDE_LIM);
        if (p > lim) begin
            return WIDE_LIM;
        end else if (p < -lim) begin
            return -WIDE_LIM;
        end
        return p[WIDE_W-1:0];
    endfunction

    assign w_p0 = t_wide'(r_knots.start_pos);
    assign w_p1 = t_wide'(r_knots.end_pos);

    always_comb begin
        case (r_op)
            3'd0:    w_sel = t_wide'(r_knots.start_vel);
            3'd1:    w_sel = t_wide'(r_knots.end_vel);
            3'd2:    w_sel = t_wide'(r_knots.start_acc);
            3'd4:    w_sel = t_wide'(r_knots.end_acc);
            default: w_sel = r_tmp;
        endcase
        w_mx   = w_sel[WIDE_W-1] ? t_mag'(-w_sel) : t_mag'(w_sel);
        w_md   = r_dur[WORD_BITS] ? (WORD_BITS+1)'(-r_dur) : (WORD_BITS+1)'(r_dur);
        w_full = {r_ph, {HALF_W{1'b0}}} + FULL_W'(r_pl);
        w_shr  = w_full[FULL_W-1:FRAC_BITS];
        w_mmag = (w_shr > SHR_LIM) ? WIDE_LIM : t_wide'(w_shr[MAG_W-1:0]);
        w_mres = r_mneg ? -w_mmag : w_mmag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // coefficients of the zero knots are derived right after reset
            r_state <= S_DUR;
            r_knots <= '0;
            r_op    <= '0;
            r_phase <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_START_TIME: r_knots.start_time <= i_cfg_data;
                CFG_END_TIME:   r_knots.end_time   <= i_cfg_data;
                CFG_START_POS:  r_knots.start_pos  <= i_cfg_data;
                CFG_START_VEL:  r_knots.start_vel  <= i_cfg_data;
                CFG_START_ACC:  r_knots.start_acc  <= i_cfg_data;
                CFG_END_POS:    r_knots.end_pos    <= i_cfg_data;
                CFG_END_VEL:    r_knots.end_vel    <= i_cfg_data;
                CFG_END_ACC:    r_knots.end_acc    <= i_cfg_data;
                default: ;
            endcase
            r_state <= S_DUR;
        end else begin
            case (r_state)
                S_IDLE: ;
                S_DUR: begin
                    r_op    <= '0;
                    r_phase <= 1'b0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_phase <= ~r_phase;
                    if (r_phase) begin
                        if (r_op == OP_W'(NUM_OPS - 1)) begin
                            r_state <= S_TERM;
                        end
                        r_op <= r_op + 1'b1;
                    end
                end
                S_TERM:  r_state <= S_CA;
                S_CA:    r_state <= S_CB;
                S_CB:    r_state <= S_CC;
                S_CC:    r_state <= S_SCALE;
                S_SCALE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers of the sequencer
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_DUR: begin
                r_dur <= {r_knots.end_time[WORD_BITS-1], r_knots.end_time}
                       - {r_knots.start_time[WORD_BITS-1], r_knots.start_time};
            end
            S_MUL: begin
                if (!r_phase) begin
                    r_pl   <= PP_W'(w_mx[HALF_W-1:0]) * PP_W'(w_md);
                    r_ph   <= PP_W'(w_mx[MAG_W-1:HALF_W]) * PP_W'(w_md);
                    r_mneg <= w_sel[WIDE_W-1] ^ r_dur[WORD_BITS];
                end else begin
                    case (r_op)
                        3'd0:    r_nv0 <= w_mres;
                        3'd1:    r_nv1 <= w_mres;
                        3'd3:    r_na0 <= w_mres;
                        3'd5:    r_na1 <= w_mres;
                        default: r_tmp <= w_mres;
                    endcase
                end
            end
            S_TERM: begin
                r_t1 <= sat_add(sat_add(r_na0, mul_k(r_nv0, 5'd2)),
                                sat_add(mul_k(w_p0, 5'd2), -mul_k(w_p1, 5'd2)));
                r_t2 <= sat_add(sat_add(r_na0, r_nv0), -r_nv1);
                r_t3 <= sat_add(r_na0, -r_na1);
            end
            S_CA: begin
                r_ca <= -sat_add(sat_add(r_t3, -mul_k(r_t2, 5'd6)), mul_k(r_t1, 5'd6));
            end
            S_CB: begin
                r_cb <= -sat_add(sat_add(mul_k(r_ca, 5'd2), mul_k(r_t2, 5'd2)),
                                 -mul_k(r_t1, 5'd3));
            end
            S_CC: begin
                r_cc <= -sat_add(sat_add(r_ca, r_cb), r_t1);
            end
            S_SCALE: begin
                // position runs five steps from A; velocity and acceleration
                // start from zero so every lane takes the same five steps
                r_init[LANE_POS]   <= r_ca;
                r_init[LANE_VEL]   <= '0;
                r_init[LANE_ACC]   <= '0;
                r_add[0][LANE_POS] <= r_cb;
                r_add[0][LANE_VEL] <= mul_k(r_ca, 5'd5);
                r_add[0][LANE_ACC] <= '0;
                r_add[1][LANE_POS] <= r_cc;
                r_add[1][LANE_VEL] <= mul_k(r_cb, 5'd4);
                r_add[1][LANE_ACC] <= mul_k(r_ca, 5'd20);
                r_add[2][LANE_POS] <= r_na0;
                r_add[2][LANE_VEL] <= mul_k(r_cc, 5'd3);
                r_add[2][LANE_ACC] <= mul_k(r_cb, 5'd12);
                r_add[3][LANE_POS] <= mul_k(r_nv0, 5'd2);
                r_add[3][LANE_VEL] <= mul_k(r_na0, 5'd2);
                r_add[3][LANE_ACC] <= mul_k(r_cc, 5'd6);
                r_add[4][LANE_POS] <= mul_k(w_p0, 5'd2);
                r_add[4][LANE_VEL] <= mul_k(r_nv0, 5'd2);
                r_add[4][LANE_ACC] <= mul_k(r_na0, 5'd2);
            end
            default: ;
        endcase
    end

    assign o_knots = r_knots;
    assign o_div   = r_dur[WORD_BITS-1:0];
    assign o_init  = r_init;
    assign o_add   = r_add;
    assign o_busy  = (r_state != S_IDLE);

endmodule

// ===== hw/rtl/qsi_fdiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment fraction divider
// Classifies the sample time and forms s = (t - t0) / D as a Q0.30 fraction,
// one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module qsi_fdiv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  qsi_pkg::t_word     i_time,
    input  qsi_pkg::t_word     i_start_time,
    input  qsi_pkg::t_word     i_end_time,
    input  qsi_pkg::t_div      i_div,
    output logic               o_valid,
    output qsi_pkg::t_frac     o_frac,
    output qsi_pkg::t_region   o_region
);
    import qsi_pkg::*;

    logic    r_valid  [FDIV_STEPS+1];
    t_div    r_rem    [FDIV_STEPS+1];
    t_frac   r_q      [FDIV_STEPS+1];
    t_region r_region [FDIV_STEPS+1];

    logic [WORD_BITS:0] w_diff;
    t_region            w_region;

    always_comb begin
        w_diff = {i_time[WORD_BITS-1], i_time} - {i_start_time[WORD_BITS-1], i_start_time};
        if (i_time <= i_start_time) begin
            w_region = REGION_START;
        end else if (i_time >= i_end_time) begin
            w_region = REGION_END;
        end else begin
            w_region = REGION_INSIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]    <= w_diff[WORD_BITS-1:0];
            r_q[0]      <= '0;
            r_region[0] <= w_region;
        end
    end

    for (genvar i = 0; i < FDIV_STEPS; i++) begin : g_bit
        logic [WORD_BITS:0] w_r2;
        logic [WORD_BITS:0] w_sub;
        logic               w_ge;

        assign w_r2  = {r_rem[i], 1'b0};
        assign w_sub = w_r2 - {1'b0, i_div};
        assign w_ge  = (w_r2 >= {1'b0, i_div});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[i+1] <= r_valid[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i+1]    <= w_ge ? w_sub[WORD_BITS-1:0] : w_r2[WORD_BITS-1:0];
                r_q[i+1]      <= {r_q[i][S_BITS-2:0], w_ge};
                r_region[i+1] <= r_region[i];
            end
        end
    end

    assign o_valid  = r_valid[FDIV_STEPS];
    assign o_frac   = r_q[FDIV_STEPS];
    assign o_region = r_region[FDIV_STEPS];

endmodule

// ===== hw/rtl/qsi_hstep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Horner step
// acc = sat(trunc(acc * s / 2^30) + add) for three lanes, over three stages:
// split partial products, recombine and shift, then sign and saturating add.
// ----------------------------------------------------------------------------
module qsi_hstep (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  qsi_pkg::t_frac     i_s,
    input  qsi_pkg::t_region   i_region,
    input  qsi_pkg::t_wide     i_acc [qsi_pkg::NUM_LANES],
    input  qsi_pkg::t_wide     i_add [qsi_pkg::NUM_LANES],
    output logic               o_valid,
    output qsi_pkg::t_frac     o_s,
    output qsi_pkg::t_region   o_region,
    output qsi_pkg::t_wide     o_acc [qsi_pkg::NUM_LANES]
);
    import qsi_pkg::*;

    localparam int PROD_W = HALF_W + S_BITS;
    localparam int FULL_W = PROD_W + HALF_W;

    logic    r_v1, r_v2, r_v3;
    t_frac   r_s1, r_s2, r_s3;
    t_region r_rg1, r_rg2, r_rg3;
    logic              r_neg1 [NUM_LANES];
    logic [PROD_W-1:0] r_pl   [NUM_LANES];
    logic [PROD_W-1:0] r_ph   [NUM_LANES];
    logic              r_neg2 [NUM_LANES];
    t_mag              r_mag2 [NUM_LANES];
    t_wide             r_acc3 [NUM_LANES];

    t_mag              w_mag  [NUM_LANES];
    logic [FULL_W-1:0] w_full [NUM_LANES];
    t_wide             w_val  [NUM_LANES];

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            w_mag[l]  = i_acc[l][WIDE_W-1] ? t_mag'(-i_acc[l]) : t_mag'(i_acc[l]);
            w_full[l] = {r_ph[l], {HALF_W{1'b0}}} + FULL_W'(r_pl[l]);
            w_val[l]  = r_neg2[l] ? -t_wide'({1'b0, r_mag2[l]}) : t_wide'({1'b0, r_mag2[l]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1  <= i_s;
            r_rg1 <= i_region;
            r_s2  <= r_s1;
            r_rg2 <= r_rg1;
            r_s3  <= r_s2;
            r_rg3 <= r_rg2;
            for (int l = 0; l < NUM_LANES; l++) begin
                r_neg1[l] <= i_acc[l][WIDE_W-1];
                r_pl[l]   <= PROD_W'(w_mag[l][HALF_W-1:0]) * PROD_W'(i_s);
                r_ph[l]   <= PROD_W'(w_mag[l][MAG_W-1:HALF_W]) * PROD_W'(i_s);
                r_neg2[l] <= r_neg1[l];
                // |acc| * s / 2^30 always stays below the internal limit
                r_mag2[l] <= w_full[l][S_BITS +: MAG_W];
                r_acc3[l] <= sat_add(w_val[l], i_add[l]);
            end
        end
    end

    assign o_valid  = r_v3;
    assign o_s      = r_s3;
    assign o_region = r_rg3;
    assign o_acc    = r_acc3;

endmodule

// ===== hw/rtl/qsi_ldiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Long divider
// q = x * 2^shift / D, truncated toward zero and saturated to the internal
// limit; one quotient bit per stage, side data carried alongside.
// ----------------------------------------------------------------------------
module qsi_ldiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  qsi_pkg::t_wide   i_x,
    input  qsi_pkg::t_shift  i_shift,
    input  qsi_pkg::t_div    i_div,
    input  qsi_pkg::t_side   i_side,
    output logic             o_valid,
    output qsi_pkg::t_wide   o_q,
    output qsi_pkg::t_side   o_side
);
    import qsi_pkg::*;

    logic  r_valid [LDIV_STEPS+1];
    t_div  r_rem   [LDIV_STEPS+1];
    t_mag  r_nq    [LDIV_STEPS+1];
    logic  r_neg   [LDIV_STEPS+1];
    logic  r_ovf   [LDIV_STEPS+1];
    t_side r_side  [LDIV_STEPS+1];
    logic  r_out_valid;
    t_wide r_out_q;
    t_side r_out_side;

    t_mag               w_mag;
    logic [NUM_W-1:0]   w_num;
    t_div               w_top;
    logic               w_ovf;
    t_wide              w_q;

    always_comb begin
        w_mag = i_x[WIDE_W-1] ? t_mag'(-i_x) : t_mag'(i_x);
        w_num = NUM_W'(w_mag) << i_shift;
        w_top = WORD_BITS'(w_num[NUM_W-1:MAG_W]);
        // quotient of 2^62 or more saturates
        w_ovf = (w_top >= i_div);
        w_q   = r_ovf[LDIV_STEPS] ? WIDE_LIM : t_wide'({1'b0, r_nq[LDIV_STEPS]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0]  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_valid[0]  <= i_valid;
            r_out_valid <= r_valid[LDIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]   <= w_ovf ? '0 : w_top;
            r_nq[0]    <= w_num[MAG_W-1:0];
            r_neg[0]   <= i_x[WIDE_W-1];
            r_ovf[0]   <= w_ovf;
            r_side[0]  <= i_side;
            r_out_q    <= r_neg[LDIV_STEPS] ? -w_q : w_q;
            r_out_side <= r_side[LDIV_STEPS];
        end
    end

    for (genvar i = 0; i < LDIV_STEPS; i++) begin : g_bit
        logic [WORD_BITS:0] w_r2;
        logic [WORD_BITS:0] w_sub;
        logic               w_ge;

        // numerator bits shift out of the top, quotient bits in at the bottom
        assign w_r2  = {r_rem[i], r_nq[i][MAG_W-1]};
        assign w_sub = w_r2 - {1'b0, i_div};
        assign w_ge  = (w_r2 >= {1'b0, i_div});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[i+1] <= r_valid[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i+1]  <= w_ge ? w_sub[WORD_BITS-1:0] : w_r2[WORD_BITS-1:0];
                r_nq[i+1]   <= {r_nq[i][MAG_W-2:0], w_ge};
                r_neg[i+1]  <= r_neg[i];
                r_ovf[i+1]  <= r_ovf[i];
                r_side[i+1] <= r_side[i];
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_q     = r_out_q;
    assign o_side  = r_out_side;

endmodule

// ===== hw/rtl/quintic_spline_interpolator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quintic spline interpolator
// Evaluates position, velocity and acceleration of one quintic Hermite
// segment between two knots at each sample time, with clamping outside.
//
//   channel  dir  handshake                     payload
//   s_axis   in   s_axis_tvalid/s_axis_tready   tdata: sample_time
//   m_axis   out  m_axis_tvalid/m_axis_tready   tdata: pos, vel, acc; tuser: region
//   cfg      in   i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// One sample per cycle unless an m_axis stall or the busy coefficient
// sequencer holds the input. Samples pass the fraction divider, the Horner
// steps, two chained long dividers and the output register; the long
// dividers, one quotient bit per stage, set the depth. After reset and
// after every register write the sequencer runs with s_axis_tready low.
// A stall on m_axis freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module quintic_spline_interpolator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [qsi_pkg::WORD_BITS-1:0]       s_axis_tdata,   // [31:0] sample_time
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [qsi_pkg::DATA_W-1:0]          m_axis_tdata,   // [31:0] position,
                                                                // [63:32] velocity,
                                                                // [95:64] acceleration
    output logic [1:0]                          m_axis_tuser,   // [1:0] region
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [qsi_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [qsi_pkg::WORD_BITS-1:0]       i_cfg_data
);
    import qsi_pkg::*;

    logic    w_en;
    logic    w_busy;
    logic    w_in_valid;
    t_knots  w_knots;
    t_div    w_div;
    t_wide   w_init [NUM_LANES];
    t_wide   w_add  [NUM_STEPS][NUM_LANES];

    logic    w_hv  [NUM_STEPS+1];
    t_frac   w_hs  [NUM_STEPS+1];
    t_region w_hr  [NUM_STEPS+1];
    t_wide   w_acc [NUM_STEPS+1][NUM_LANES];

    t_side   w_side_in;
    logic    w_vel_valid, w_a1_valid, w_a2_valid;
    t_wide   w_vel_q, w_a1_q, w_a2_q;
    t_side   w_vel_side, w_a1_side, w_a2_side, w_a2_in_side;

    t_wide   w_pos_half;
    t_word   w_pos, w_vel, w_acc_o;

    logic    r_out_valid;
    t_word   r_out_pos, r_out_vel, r_out_acc;
    t_region r_out_region;

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en && !w_busy;
    assign w_in_valid    = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    qsi_coef u_coef (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_knots     (w_knots),
        .o_div       (w_div),
        .o_init      (w_init),
        .o_add       (w_add),
        .o_busy      (w_busy)
    );

    qsi_fdiv u_fdiv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (w_in_valid),
        .i_time       (s_axis_tdata),
        .i_start_time (w_knots.start_time),
        .i_end_time   (w_knots.end_time),
        .i_div        (w_div),
        .o_valid      (w_hv[0]),
        .o_frac       (w_hs[0]),
        .o_region     (w_hr[0])
    );

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            w_acc[0][l] = w_init[l];
        end
    end

    for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
        qsi_hstep u_hstep (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_valid  (w_hv[k]),
            .i_s      (w_hs[k]),
            .i_region (w_hr[k]),
            .i_acc    (w_acc[k]),
            .i_add    (w_add[k]),
            .o_valid  (w_hv[k+1]),
            .o_s      (w_hs[k+1]),
            .o_region (w_hr[k+1]),
            .o_acc    (w_acc[k+1])
        );
    end

    assign w_side_in = '{region: w_hr[NUM_STEPS], pos: w_acc[NUM_STEPS][LANE_POS], aux: '0};

    qsi_ldiv u_ldiv_vel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_hv[NUM_STEPS]),
        .i_x     (w_acc[NUM_STEPS][LANE_VEL]),
        .i_shift (SHIFT_VEL),
        .i_div   (w_div),
        .i_side  (w_side_in),
        .o_valid (w_vel_valid),
        .o_q     (w_vel_q),
        .o_side  (w_vel_side)
    );

    qsi_ldiv u_ldiv_acc1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_hv[NUM_STEPS]),
        .i_x     (w_acc[NUM_STEPS][LANE_ACC]),
        .i_shift (SHIFT_VEL),
        .i_div   (w_div),
        .i_side  (w_side_in),
        .o_valid (w_a1_valid),
        .o_q     (w_a1_q),
        .o_side  (w_a1_side)
    );

    assign w_a2_in_side = '{region: w_a1_side.region, pos: w_vel_side.pos, aux: w_vel_q};

    qsi_ldiv u_ldiv_acc2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_vel_valid && w_a1_valid),
        .i_x     (w_a1_q),
        .i_shift (SHIFT_ACC),
        .i_div   (w_div),
        .i_side  (w_a2_in_side),
        .o_valid (w_a2_valid),
        .o_q     (w_a2_q),
        .o_side  (w_a2_side)
    );

    always_comb begin
        // halve position, truncating toward zero
        w_pos_half = (w_a2_side.pos + t_wide'(w_a2_side.pos[WIDE_W-1])) >>> 1;
        case (w_a2_side.region)
            REGION_START: begin
                w_pos   = w_knots.start_pos;
                w_vel   = w_knots.start_vel;
                w_acc_o = w_knots.start_acc;
            end
            REGION_END: begin
                w_pos   = w_knots.end_pos;
                w_vel   = w_knots.end_vel;
                w_acc_o = w_knots.end_acc;
            end
            default: begin
                w_pos   = sat_word(w_pos_half);
                w_vel   = sat_word(w_a2_side.aux);
                w_acc_o = sat_word(w_a2_q);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_a2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_pos    <= w_pos;
            r_out_vel    <= w_vel;
            r_out_acc    <= w_acc_o;
            r_out_region <= w_a2_side.region;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_acc, r_out_vel, r_out_pos};
    assign m_axis_tuser  = r_out_region;

endmodule

// ===== sim/quintic_spline_interpolator_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quintic spline interpolator testbench
// Streams sample times through the interpolator under several knot settings
// and compares each result against a bit-exact fixed-point predictor, with
// bursty input traffic and a stalling output side.
// ----------------------------------------------------------------------------
module quintic_spline_interpolator_unit_test;
    import qsi_pkg::*;

    localparam int CLK_HALF   = 10;
    localparam int LATENCY    = 175;
    localparam int CYCLE_LIMIT = 400000;
    localparam longint LIM    = 64'h3FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [31:0] pos;
        logic [31:0] vel;
        logic [31:0] acc;
        logic [1:0]  region;
    } t_expect;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [WORD_BITS-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WORD_BITS-1:0] i_cfg_data = '0;

    quintic_spline_interpolator_unit dut (.*);

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    longint knot [8];
    logic [31:0] pending_times[$];
    t_expect expected_results[$];
    int mismatches = 0;
    int cycles = 0;
    int sent = 0, received = 0, inside_cnt = 0;
    int gap_left = 0, burst_left = 0, stall_phase = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("quintic_spline_interpolator_unit verification failed");
            $finish;
        end
    end

    // saturating wide arithmetic in the same Q format as the block
    function automatic longint sat_sum(longint a, longint b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(LIM)) return LIM;
        if (s < -65'(LIM)) return -LIM;
        return longint'(s);
    endfunction

    function automatic longint mul_shift(longint a, longint b, int sh);
        logic [127:0] ua, ub, pr;
        logic neg;
        neg = (a < 0) != (b < 0);
        ua = a < 0 ? 128'(-a) : 128'(a);
        ub = b < 0 ? 128'(-b) : 128'(b);
        pr = (ua * ub) >> sh;
        if (pr > 128'(LIM)) pr = 128'(LIM);
        return neg ? -longint'(pr) : longint'(pr);
    endfunction

    function automatic longint div_scaled(longint n, longint d, int m);
        logic [63:0] ud, mag, q, r;
        logic neg;
        if (d <= 0) return 0;
        neg = n < 0;
        ud = d;
        mag = neg ? -n : n;
        q = mag / ud;
        r = mag % ud;
        for (int i = 0; i < m && q <= LIM; i++) begin
            q = q << 1;
            r = r << 1;
            if (r >= ud) begin
                q = q + 1;
                r = r - ud;
            end
        end
        if (q > LIM) q = LIM;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [31:0] clip_word(longint v);
        if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (v < -64'sh8000_0000) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic longint step_h(longint acc, longint s, longint add);
        return sat_sum(mul_shift(acc, s, S_BITS), add);
    endfunction

    function automatic t_expect spline_eval(logic [31:0] raw);
        t_expect e;
        longint t, dur, s, nv0, nv1, na0, na1, t1, t2, t3, ca, cb, cc, cd, ce, cf, p, v, a;
        t = longint'($signed(raw));
        if (t <= knot[CFG_START_TIME]) begin
            e = '{clip_word(knot[CFG_START_POS]), clip_word(knot[CFG_START_VEL]),
                  clip_word(knot[CFG_START_ACC]), REGION_START};
            return e;
        end
        if (t >= knot[CFG_END_TIME]) begin
            e = '{clip_word(knot[CFG_END_POS]), clip_word(knot[CFG_END_VEL]),
                  clip_word(knot[CFG_END_ACC]), REGION_END};
            return e;
        end
        dur = knot[CFG_END_TIME] - knot[CFG_START_TIME];
        s = div_scaled(t - knot[CFG_START_TIME], dur, S_BITS);
        nv0 = mul_shift(knot[CFG_START_VEL], dur, FRAC_BITS);
        nv1 = mul_shift(knot[CFG_END_VEL], dur, FRAC_BITS);
        na0 = mul_shift(mul_shift(knot[CFG_START_ACC], dur, FRAC_BITS), dur, FRAC_BITS);
        na1 = mul_shift(mul_shift(knot[CFG_END_ACC], dur, FRAC_BITS), dur, FRAC_BITS);
        t1 = sat_sum(sat_sum(na0, mul_shift(nv0, 2, 0)),
                     sat_sum(mul_shift(knot[CFG_START_POS], 2, 0),
                             -mul_shift(knot[CFG_END_POS], 2, 0)));
        t2 = sat_sum(sat_sum(na0, nv0), -nv1);
        t3 = sat_sum(na0, -na1);
        ca = -sat_sum(sat_sum(t3, -mul_shift(t2, 6, 0)), mul_shift(t1, 6, 0));
        cb = -sat_sum(sat_sum(mul_shift(ca, 2, 0), mul_shift(t2, 2, 0)),
                      -mul_shift(t1, 3, 0));
        cc = -sat_sum(sat_sum(ca, cb), t1);
        cd = na0;
        ce = mul_shift(nv0, 2, 0);
        cf = mul_shift(knot[CFG_START_POS], 2, 0);
        p = step_h(ca, s, cb);
        p = step_h(p, s, cc);
        p = step_h(p, s, cd);
        p = step_h(p, s, ce);
        p = step_h(p, s, cf);
        p = mul_shift(p, 1, 1);
        v = step_h(mul_shift(ca, 5, 0), s, mul_shift(cb, 4, 0));
        v = step_h(v, s, mul_shift(cc, 3, 0));
        v = step_h(v, s, mul_shift(cd, 2, 0));
        v = step_h(v, s, ce);
        v = div_scaled(v, dur, FRAC_BITS - 1);
        a = step_h(mul_shift(ca, 20, 0), s, mul_shift(cb, 12, 0));
        a = step_h(a, s, mul_shift(cc, 6, 0));
        a = step_h(a, s, mul_shift(cd, 2, 0));
        a = div_scaled(div_scaled(a, dur, FRAC_BITS - 1), dur, FRAC_BITS);
        e = '{clip_word(p), clip_word(v), clip_word(a), REGION_INSIDE};
        return e;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, received);
        mismatches++;
    endtask

    // driver: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(spline_eval(s_axis_tdata));
                sent <= sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_times.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_times.pop_front();
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: stall pattern cycles through free-running, light and heavy stalls
    always @(posedge i_clk) begin
        t_expect w;
        if (i_rst_n) begin
            stall_phase <= (stall_phase + 1) % 600;
            if (stall_phase < 200) m_axis_tready <= 1'b1;
            else if (stall_phase < 400) m_axis_tready <= ($urandom_range(0, 3) != 0);
            else m_axis_tready <= ($urandom_range(0, 3) == 0);
            if (m_axis_tvalid && m_axis_tready) begin
                received <= received + 1;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transfer", m_axis_tdata[31:0], 32'h0);
                end else begin
                    w = expected_results.pop_front();
                    if (w.region == REGION_INSIDE) inside_cnt <= inside_cnt + 1;
                    if (m_axis_tdata[31:0] !== w.pos)
                        report_mismatch("position", m_axis_tdata[31:0], w.pos);
                    if (m_axis_tdata[63:32] !== w.vel)
                        report_mismatch("velocity", m_axis_tdata[63:32], w.vel);
                    if (m_axis_tdata[95:64] !== w.acc)
                        report_mismatch("acceleration", m_axis_tdata[95:64], w.acc);
                    if (m_axis_tuser !== w.region)
                        report_mismatch("region", 32'(m_axis_tuser), 32'(w.region));
                end
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx <= CFG_END_ACC) knot[idx] = longint'($signed(val));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_bad_index(logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_IDX_W'(8 + $urandom_range(0, 7));
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_times.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] time_between(longint lo, longint hi);
        longint span;
        span = hi - lo;
        if (span <= 0) return lo[31:0];
        return 32'(lo + longint'({$urandom, $urandom} % span) + 1);
    endfunction

    task automatic load_knots(logic [31:0] k [8]);
        for (int i = 0; i < 8; i++) write_reg(t_cfg_idx'(i), k[i]);
    endtask

    logic [31:0] setting [8];
    logic [31:0] times [$];

    initial begin
        for (int i = 0; i < 8; i++) knot[i] = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero knots at reset, then extremes of sample_time
        times = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF};
        foreach (times[i]) pending_times.push_back(times[i]);
        wait_drained();

        // one-second segment with moderate knots
        setting = '{32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'hFFFF_0000,
                    32'h0002_0000, 32'h0003_0000, 32'h0000_4000, 32'hFFFE_0000};
        load_knots(setting);
        write_bad_index(32'hDEAD_BEEF);
        times = '{32'h0001_0000, 32'h0002_0000, 32'h0001_0001, 32'h0001_FFFF,
                  32'h0001_8000, 32'h0000_FFFF, 32'h0002_0001, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h0001_4000};
        foreach (times[i]) pending_times.push_back(times[i]);
        wait_drained();

        // two-LSB segment: a single interior point
        setting = '{32'h0000_0010, 32'h0000_0012, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        load_knots(setting);
        times = '{32'h0000_0011, 32'h0000_0010, 32'h0000_0012};
        foreach (times[i]) pending_times.push_back(times[i]);
        wait_drained();

        // reversed knot times fall entirely into the clamps
        setting = '{32'h0005_0000, 32'h0001_0000, 32'h1234_5678, 32'h8765_4321,
                    32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
        load_knots(setting);
        times = '{32'h0003_0000, 32'h0005_0000, 32'h0005_0001, 32'h0000_0000};
        foreach (times[i]) pending_times.push_back(times[i]);
        wait_drained();

        // random phases: random knots, mostly interior sample times
        for (int ph = 0; ph < 6; ph++) begin
            longint t0, t1;
            for (int i = 0; i < 8; i++) setting[i] = $urandom;
            if (ph == 0) begin
                setting[CFG_START_TIME] = 32'h8000_0000;
                setting[CFG_END_TIME] = 32'h7FFF_FFFF;
            end else if (ph < 4) begin
                setting[CFG_END_TIME] = setting[CFG_START_TIME] + $urandom_range(2, 32'h0008_0000);
                if (ph == 1)
                    for (int i = 2; i < 8; i++) setting[i] = $signed(setting[i]) >>> 12;
            end
            load_knots(setting);
            t0 = knot[CFG_START_TIME];
            t1 = knot[CFG_END_TIME];
            repeat (70) begin
                if ($urandom_range(0, 9) < 8 && t1 > t0 + 1)
                    pending_times.push_back(time_between(t0, t1 - 1));
                else if ($urandom_range(0, 1) == 0)
                    pending_times.push_back($urandom);
                else
                    pending_times.push_back($urandom_range(0, 1) ? t0[31:0] : t1[31:0]);
            end
            wait_drained();
        end

        $display("applied %0d sample times over 10 knot settings; %0d results, %0d inside",
                 sent, received, inside_cnt);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("quintic_spline_interpolator_unit verification clean");
        end else begin
            $display("quintic_spline_interpolator_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/qsi_pkg.sv
hw/rtl/qsi_coef.sv
hw/rtl/qsi_fdiv.sv
hw/rtl/qsi_hstep.sv
hw/rtl/qsi_ldiv.sv
hw/rtl/quintic_spline_interpolator_unit.sv
sim/quintic_spline_interpolator_unit_test.sv
